/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the slot table
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in any cycle in which ante holds
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* rtl/nfst_pkg.sv */
// package for the next-fit slot table: command and result codes,
// sequencer state type and fixed field widths; no dependencies
package nfst_pkg;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 16;
	localparam int SLOT_IN_W  = 6;
	localparam int SLOT_OUT_W = 5;
	localparam int KIND_W   = 2;
	localparam int CNT_W    = 5;
	localparam int RES_MAX  = 31;

	localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_BCAST    = 2'd2;

	localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SCAN,
		ST_CAPT,
		ST_FLUSH
	} nfst_state_t;

endpackage

/* rtl/next_fit_slot_table_top.sv */
// next-fit slot table top level: sequencer, in-use flags, handle memory
// depends on nfst_pkg and assert_macros.svh
`include "assert_macros.svh"

// A table of SLOTS slots, each with an in-use flag (flip-flops, cleared by
// reset) and a 16-bit handle held in a single-port memory. One index
// register with its incrementer and wrap compare is the shared unit that
// register and broadcast commands walk. A register command (tuser opcode
// 0) tests one slot per cycle starting at the rotating search pointer; the
// first free slot is claimed, its handle stored, the pointer moved past it
// and a grant beat sent, or a table-full beat is sent after SLOTS tested
// slots. A remove command frees the slot in the accept cycle and sends
// nothing. A broadcast command scans slots 0..SLOTS-1 one per cycle,
// pausing at each target to read its handle from the memory and stalling
// there while the output register cannot take a beat. Targets go out in
// slot order, the final one with tlast; at most 31 beats, and none when no
// slot qualifies. One beat of lookahead is held so tlast can be set on the
// right beat. The input is taken only while the sequencer is idle, but a
// finished result may still sit in the output register while the next
// command is taken.
module next_fit_slot_table_top
	import nfst_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [15:0] handle, [21:16] slot, [23:22] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [4:0] slot_out, [20:5] handle_out, [23:21] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last beat caused by a command
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	// input beat fields
	logic [OP_W-1:0]      in_op;
	logic [HANDLE_W-1:0]  in_handle;
	logic [SLOT_IN_W-1:0] in_slot;
	logic                 in_accept;

	assign in_op     = s_axis_tuser;
	assign in_handle = s_axis_tdata[15:0];
	assign in_slot   = s_axis_tdata[21:16];

	// sequencer and shared index unit
	nfst_state_t         state_q, state_d;
	logic [SLOT_W-1:0]   idx_q, idx_d, idx_inc;
	logic [SLOT_W-1:0]   step_q, step_d;
	logic [SLOT_W-1:0]   start_q, start_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;

	// command payload held for the duration of a command
	logic [HANDLE_W-1:0]  cmd_handle_q;
	logic [SLOT_IN_W-1:0] origin_q;

	// slot state
	logic [SLOTS-1:0]    in_use_q;
	logic [HANDLE_W-1:0] handle_mem [SLOTS];
	logic [HANDLE_W-1:0] rd_q;
	logic                mem_we;
	logic                set_use;
	logic                clr_use;
	logic [SLOT_W-1:0]   rm_idx;

	// lookahead target waiting for its successor
	logic                pend_v_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic                load_pend;
	logic                clear_pend;

	// output register
	logic                  out_v_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  push;
	logic [KIND_W-1:0]     push_kind;
	logic [SLOT_OUT_W-1:0] push_slot;
	logic [HANDLE_W-1:0]   push_handle;
	logic                  push_last;

	logic hit;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_v_q || m_axis_tready;
	assign idx_inc   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign rm_idx    = in_slot[SLOT_W-1:0];
	// broadcast target: in use and not the origin
	assign hit       = in_use_q[idx_q] && (SLOT_IN_W'(idx_q) != origin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			step_q   <= '0;
			start_q  <= '0;
			cnt_q    <= '0;
			in_use_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
			if (set_use) begin
				in_use_q[idx_q] <= 1'b1;
			end
			if (clr_use) begin
				in_use_q[rm_idx] <= 1'b0;
			end
			if (load_pend) begin
				pend_v_q <= 1'b1;
			end else if (clear_pend) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_handle_q <= in_handle;
			origin_q     <= in_slot;
		end
		if (load_pend) begin
			pend_slot_q   <= idx_q;
			pend_handle_q <= rd_q;
		end
		if (push) begin
			out_kind_q   <= push_kind;
			out_slot_q   <= push_slot;
			out_handle_q <= push_handle;
			out_last_q   <= push_last;
		end
	end

	// handle memory: one address per cycle, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			handle_mem[idx_q] <= cmd_handle_q;
		end
		rd_q <= handle_mem[idx_q];
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		step_d      = step_q;
		start_d     = start_q;
		cnt_d       = cnt_q;
		mem_we      = 1'b0;
		set_use     = 1'b0;
		clr_use     = 1'b0;
		load_pend   = 1'b0;
		clear_pend  = 1'b0;
		push        = 1'b0;
		push_kind   = KIND_GRANT;
		push_slot   = '0;
		push_handle = '0;
		push_last   = 1'b1;
		s_axis_tready = (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (in_op)
						OP_REGISTER: begin
							idx_d   = start_q;
							step_d  = '0;
							state_d = ST_SEARCH;
						end
						OP_REMOVE: begin
							if ((in_slot < SLOT_IN_W'(SLOTS)) && in_use_q[rm_idx]) begin
								clr_use = 1'b1;
							end
						end
						OP_BCAST: begin
							idx_d   = '0;
							cnt_d   = '0;
							state_d = ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (!in_use_q[idx_q]) begin
					// free slot: claim it once the output register can take the beat
					if (out_free) begin
						push      = 1'b1;
						push_kind = KIND_GRANT;
						push_slot = SLOT_OUT_W'(idx_q);
						mem_we    = 1'b1;
						set_use   = 1'b1;
						start_d   = idx_inc;
						state_d   = ST_IDLE;
					end
				end else if (step_q == LAST_IDX) begin
					// every slot tested and taken
					if (out_free) begin
						push      = 1'b1;
						push_kind = KIND_FULL;
						state_d   = ST_IDLE;
					end
				end else begin
					idx_d  = idx_inc;
					step_d = step_q + 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					// handle read issued here, captured in ST_CAPT
					state_d = ST_CAPT;
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end else begin
					idx_d = idx_inc;
				end
			end
			ST_CAPT: begin
				if (!pend_v_q || out_free) begin
					if (pend_v_q) begin
						push        = 1'b1;
						push_kind   = KIND_TARGET;
						push_slot   = SLOT_OUT_W'(pend_slot_q);
						push_handle = pend_handle_q;
						push_last   = 1'b0;
					end
					load_pend = 1'b1;
					cnt_d     = cnt_q + 1'b1;
					if ((cnt_q + 1'b1 == CNT_W'(RES_MAX)) || (idx_q == LAST_IDX)) begin
						state_d = ST_FLUSH;
					end else begin
						idx_d   = idx_inc;
						state_d = ST_SCAN;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push        = 1'b1;
					push_kind   = KIND_TARGET;
					push_slot   = SLOT_OUT_W'(pend_slot_q);
					push_handle = pend_handle_q;
					push_last   = 1'b1;
					clear_pend  = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, out_handle_q, out_slot_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// a new beat never overwrites one that has not been taken
	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, push, out_free)
	// table full is only reported with every slot in use
	`ASSERT_IMPLY(a_full_only_when_full, clk, arst_n,
		push && (push_kind == KIND_FULL), in_use_q == {SLOTS{1'b1}})
	// no lookahead target is left behind when the sequencer is idle
	`ASSERT_NEVER(a_no_stale_pending, clk, arst_n, (state_q == ST_IDLE) && pend_v_q)

endmodule
